// ===== rtl/hjal_pkg.sv =====
package hjal_pkg;

    localparam int STEPS      = 20;
    localparam int NEAR_ZERO  = 2;
    localparam int CHANGE_TOL = 1;

    // datapath widths: normalizer, vectoring CORDIC, angle, rotation CORDIC
    localparam int NW = 68;
    localparam int VW = 45;
    localparam int ZW = 25;
    localparam int RW = 34;

    localparam int NDN = 5;
    localparam int NUP = 6;

    localparam logic signed [ZW-1:0] PI_Q20      = 25'sd3294199;
    localparam logic signed [ZW-1:0] HALF_PI_Q20 = 25'sd1647099;
    localparam logic signed [19:0]   TWO_PI_Q12  = 20'sd25736;
    localparam logic signed [RW-1:0] GAIN_Q30    = 34'sd652032874;

    // vectoring target window [2^40, 2^41)
    localparam logic signed [NW-1:0] NORM_HI = NW'(64'sd1 <<< 41);
    localparam logic signed [NW-1:0] NORM_LO = NW'(64'sd1 <<< 40);

    localparam logic [19:0] ATAN_Q20 [STEPS] = '{
        20'd823550, 20'd486170, 20'd256879, 20'd130396, 20'd65451,
        20'd32757,  20'd16383,  20'd8192,   20'd4096,   20'd2048,
        20'd1024,   20'd512,    20'd256,    20'd128,    20'd64,
        20'd32,     20'd16,     20'd8,      20'd4,      20'd2
    };

    localparam logic [5:0] DN_SH [NDN] = '{6'd16, 6'd8, 6'd4, 6'd2, 6'd1};
    localparam logic [5:0] UP_SH [NUP] = '{6'd32, 6'd16, 6'd8, 6'd4, 6'd2, 6'd1};

    typedef enum logic [2:0] {
        CFG_FWD_X   = 3'd0,
        CFG_FWD_Y   = 3'd1,
        CFG_FWD_Z   = 3'd2,
        CFG_HINGE_X = 3'd3,
        CFG_HINGE_Y = 3'd4,
        CFG_HINGE_Z = 3'd5,
        CFG_LOWER   = 3'd6,
        CFG_UPPER   = 3'd7
    } cfg_idx_t;

    // per-transaction side band that rides along the pipeline
    typedef struct packed {
        logic signed [15:0]   w;
        logic signed [15:0]   x;
        logic signed [15:0]   y;
        logic signed [15:0]   z;
        logic                 near;
        logic                 fix;
        logic                 fix_neg;
        logic                 hneg;
        logic signed [ZW-1:0] z0;
    } side_t;

endpackage

// ===== rtl/hjal_cfg_if.sv =====
interface hjal_cfg_if import hjal_pkg::*;;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/hjal_in_if.sv =====
interface hjal_in_if import hjal_pkg::*;;
    logic               valid;
    logic               ready;
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;

    modport source (output valid, output w, output x, output y, output z, input ready);
    modport sink   (input valid, input w, input x, input y, input z, output ready);
endinterface

// ===== rtl/hjal_out_if.sv =====
interface hjal_out_if import hjal_pkg::*;;
    logic               valid;
    logic               ready;
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               applied;

    modport source (output valid, output w, output x, output y, output z, output applied,
                    input ready);
    modport sink   (input valid, input w, input x, input y, input z, input applied,
                    output ready);
endinterface

// ===== rtl/hinge_joint_angle_limit.sv =====
// Hinge joint angle limit.
// cfg: write channel, index selects fwd_x/y/z, hinge_x/y/z, lower/upper limit.
//   Always ready; write only while the block is drained.
// sample: joint rotation quaternion (w, x, y, z), Q1.14, one transaction per cycle unless stalled.
// result: constrained quaternion plus the applied flag, one per sample, in order.
// Pipeline: stage 0 loads on the accepting edge, then 61 more pipeline stages and
//   the output register. Throughput: one transaction per cycle while the output
//   is not stalled, set by the fully pipelined datapath: two 20-cell
//   CORDIC chains (vectoring for the hinge angle, rotation for the half-angle
//   sine/cosine) and an 11-cell shift normalizer.
// Reset: valid bits clear, config returns to forward +x, hinge +z, limits +/-pi.
// Stall: when result is not taken the whole pipeline freezes and sample.ready
//   drops in the same cycle; nothing is lost or duplicated. The output register
//   lets a new sample enter the same cycle a held result is taken.
module hinge_joint_angle_limit import hjal_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    hjal_cfg_if.sink    cfg,
    hjal_in_if.sink     sample,
    hjal_out_if.source  result
);

    // stage map
    localparam int S_T    = 0;               // t = 2 (u x f)
    localparam int S_V    = 1;               // rotated forward axis
    localparam int S_D    = 2;               // v . h
    localparam int S_P    = 3;               // projection onto hinge plane
    localparam int S_FP   = 4;               // f x p, f . p, short test
    localparam int S_S    = 5;               // (f x p) . h
    localparam int S_PREP = 6;               // half-plane fold
    localparam int S_NORM = S_PREP + NDN + NUP;
    localparam int S_VEC  = S_NORM + STEPS;
    localparam int S_ANG  = S_VEC + 1;
    localparam int S_PHI  = S_ANG + 1;
    localparam int S_HALF = S_PHI + 1;
    localparam int S_ROT  = S_HALF + STEPS;
    localparam int S_QUAT = S_ROT + 1;
    localparam int NST    = S_QUAT + 1;

    // ---------------- configuration registers ----------------
    logic signed [15:0] fwd_x_reg, fwd_y_reg, fwd_z_reg;
    logic signed [15:0] hinge_x_reg, hinge_y_reg, hinge_z_reg;
    logic signed [14:0] lower_reg, upper_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_x_reg   <= 16'sd16384;
            fwd_y_reg   <= '0;
            fwd_z_reg   <= '0;
            hinge_x_reg <= '0;
            hinge_y_reg <= '0;
            hinge_z_reg <= 16'sd16384;
            lower_reg   <= -15'sd12868;
            upper_reg   <= 15'sd12868;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_FWD_X:   fwd_x_reg   <= cfg.data;
                CFG_FWD_Y:   fwd_y_reg   <= cfg.data;
                CFG_FWD_Z:   fwd_z_reg   <= cfg.data;
                CFG_HINGE_X: hinge_x_reg <= cfg.data;
                CFG_HINGE_Y: hinge_y_reg <= cfg.data;
                CFG_HINGE_Z: hinge_z_reg <= cfg.data;
                CFG_LOWER:   lower_reg   <= cfg.data[14:0];
                CFG_UPPER:   upper_reg   <= cfg.data[14:0];
            endcase
        end
    end

    // ---------------- flow control ----------------
    // Single global advance: every stage moves when the output slot is free
    // or being emptied.
    logic en;
    logic res_vld_reg;

    assign en           = !res_vld_reg || result.ready;
    assign sample.ready = en;

    logic [NST-1:0] vld_reg;
    side_t          side_reg [NST];
    side_t          side_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], sample.valid};
    end

    always_comb
    begin
        side_in         = '0;
        side_in.w       = sample.w;
        side_in.x       = sample.x;
        side_in.y       = sample.y;
        side_in.z       = sample.z;
    end

    // ---------------- stage S_T: t = 2 (u x f) ----------------
    logic signed [32:0] c1 [3];
    logic signed [33:0] t_reg [3];

    always_comb
    begin
        c1[0] = sample.y * fwd_z_reg - sample.z * fwd_y_reg;
        c1[1] = sample.z * fwd_x_reg - sample.x * fwd_z_reg;
        c1[2] = sample.x * fwd_y_reg - sample.y * fwd_x_reg;
    end

    // ---------------- stage S_V: v = f + w t + u x t ----------------
    logic signed [52:0] vf [3];
    logic signed [52:0] vr [3];
    logic signed [24:0] v_reg [3];
    logic signed [15:0] qw, qx, qy, qz;

    always_comb
    begin
        qw = side_reg[S_T].w;
        qx = side_reg[S_T].x;
        qy = side_reg[S_T].y;
        qz = side_reg[S_T].z;
        vf[0] = (fwd_x_reg <<< 28) + qw * t_reg[0] + (qy * t_reg[2] - qz * t_reg[1]);
        vf[1] = (fwd_y_reg <<< 28) + qw * t_reg[1] + (qz * t_reg[0] - qx * t_reg[2]);
        vf[2] = (fwd_z_reg <<< 28) + qw * t_reg[2] + (qx * t_reg[1] - qy * t_reg[0]);
        for (int k = 0; k < 3; k++)
            vr[k] = (vf[k] + 53'sd134217728) >>> 28;
    end

    // ---------------- stage S_D: d = v . h ----------------
    logic signed [42:0] d_c, d_reg;
    logic signed [24:0] v2_reg [3];

    assign d_c = v_reg[0] * hinge_x_reg + v_reg[1] * hinge_y_reg + v_reg[2] * hinge_z_reg;

    // ---------------- stage S_P: p = v - d h ----------------
    logic signed [60:0] pf [3];
    logic signed [60:0] pr [3];
    logic signed [31:0] p_reg [3];

    always_comb
    begin
        pf[0] = (v2_reg[0] <<< 28) - d_reg * hinge_x_reg;
        pf[1] = (v2_reg[1] <<< 28) - d_reg * hinge_y_reg;
        pf[2] = (v2_reg[2] <<< 28) - d_reg * hinge_z_reg;
        for (int k = 0; k < 3; k++)
            pr[k] = (pf[k] + 61'sd134217728) >>> 28;
    end

    // ---------------- stage S_FP: f x p, f . p, short remainder ----------------
    logic signed [48:0] fp_c [3];
    logic signed [48:0] fp_reg [3];
    logic signed [49:0] c_c, c4_reg, c5_reg;
    logic               all_small, near_c;
    logic signed [10:0] ps [3];
    logic [23:0]        len2;

    always_comb
    begin
        fp_c[0] = fwd_y_reg * p_reg[2] - fwd_z_reg * p_reg[1];
        fp_c[1] = fwd_z_reg * p_reg[0] - fwd_x_reg * p_reg[2];
        fp_c[2] = fwd_x_reg * p_reg[1] - fwd_y_reg * p_reg[0];
        c_c     = fwd_x_reg * p_reg[0] + fwd_y_reg * p_reg[1] + fwd_z_reg * p_reg[2];
        // |p|^2 below NEAR_ZERO^2 needs every component below NEAR_ZERO,
        // so the square is taken on narrow values only
        all_small = 1'b1;
        len2      = '0;
        for (int k = 0; k < 3; k++)
        begin
            all_small = all_small && (p_reg[k] > -32'(NEAR_ZERO)) && (p_reg[k] < 32'(NEAR_ZERO));
            ps[k]     = p_reg[k][10:0];
            len2      = len2 + 24'(ps[k] * ps[k]);
        end
        near_c = all_small && (len2 < 24'(NEAR_ZERO * NEAR_ZERO));
    end

    // ---------------- stage S_S: s = (f x p) . h ----------------
    logic signed [66:0] s_c, s_reg;

    assign s_c = fp_reg[0] * hinge_x_reg + fp_reg[1] * hinge_y_reg + fp_reg[2] * hinge_z_reg;

    // ---------------- stage S_PREP: fold into right half plane ----------------
    logic signed [NW-1:0] px_c, py_c, cx, sx;
    logic signed [ZW-1:0] pz_c;
    logic                 c_neg, s_zero, s_pos;

    always_comb
    begin
        c_neg  = c5_reg[49];
        s_zero = (s_reg == '0);
        s_pos  = !s_reg[66] && !s_zero;
        cx     = NW'(c5_reg);
        sx     = NW'(s_reg);
        px_c   = c_neg ? -cx : cx;
        py_c   = c_neg ? -sx : sx;
        if (!c_neg)
            pz_c = '0;
        else
            pz_c = s_pos ? PI_Q20 : -PI_Q20;
    end

    // ---------------- normalizer: scale max(x,|y|) into [2^40, 2^41) ----------------
    logic signed [NW-1:0] nx [NDN+NUP+1];
    logic signed [NW-1:0] ny [NDN+NUP+1];
    logic signed [NW-1:0] nx0_reg, ny0_reg;

    assign nx[0] = nx0_reg;
    assign ny[0] = ny0_reg;

    for (genvar j = 0; j < NDN; j++)
    begin : g_dn
        hjal_dn_cell u_dn (
            .clk   (clk),
            .en    (en),
            .sh    (DN_SH[j]),
            .x_in  (nx[j]),
            .y_in  (ny[j]),
            .x_reg (nx[j+1]),
            .y_reg (ny[j+1])
        );
    end

    for (genvar j = 0; j < NUP; j++)
    begin : g_up
        hjal_up_cell u_up (
            .clk   (clk),
            .en    (en),
            .sh    (UP_SH[j]),
            .x_in  (nx[NDN+j]),
            .y_in  (ny[NDN+j]),
            .x_reg (nx[NDN+j+1]),
            .y_reg (ny[NDN+j+1])
        );
    end

    // ---------------- vectoring CORDIC: atan2(s, c) in Q.20 ----------------
    logic signed [VW-1:0] vx [STEPS+1];
    logic signed [VW-1:0] vy [STEPS+1];
    logic signed [ZW-1:0] vz [STEPS+1];

    assign vx[0] = nx[NDN+NUP][VW-1:0];
    assign vy[0] = ny[NDN+NUP][VW-1:0];
    assign vz[0] = side_reg[S_NORM].z0;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_vec
        hjal_vec_cell u_vec (
            .clk   (clk),
            .en    (en),
            .idx   (5'(i)),
            .x_in  (vx[i]),
            .y_in  (vy[i]),
            .z_in  (vz[i]),
            .x_reg (vx[i+1]),
            .y_reg (vy[i+1]),
            .z_reg (vz[i+1])
        );
    end

    // ---------------- stage S_ANG: angle to Q3.12 ----------------
    logic signed [ZW-1:0] ang_c;
    logic signed [ZW:0]   ar_c;
    logic signed [17:0]   a_reg;

    always_comb
    begin
        // zero sine: straight ahead or exactly opposite
        if (side_reg[S_VEC].fix)
            ang_c = side_reg[S_VEC].fix_neg ? -PI_Q20 : '0;
        else
            ang_c = vz[STEPS];
        ar_c = ((ZW+1)'(ang_c) + 26'sd128) >>> 8;
    end

    // ---------------- stage S_PHI: clamp to nearer limit with wrap ----------------
    logic signed [19:0]   a20, lo20, hi20, mind, maxd, alt, ac;
    logic signed [ZW-1:0] phi_c, phi_reg;

    always_comb
    begin
        a20  = 20'(a_reg);
        lo20 = 20'(lower_reg);
        hi20 = 20'(upper_reg);
        mind = a20 - lo20;
        maxd = a20 - hi20;
        ac   = a20;
        alt  = '0;
        if (maxd > 20'sd0)
        begin
            alt = lo20 + TWO_PI_Q12 - a20;
            if (alt < mind)
                mind = alt;
            ac = (mind < maxd) ? lo20 : hi20;
        end
        else if (mind < 20'sd0)
        begin
            alt = hi20 - TWO_PI_Q12 - a20;
            if (alt > maxd)
                maxd = alt;
            ac = (mind > maxd) ? lo20 : hi20;
        end
        // short remainder: middle of the range
        if (side_reg[S_ANG].near)
            phi_c = (ZW'(lower_reg) + ZW'(upper_reg)) <<< 6;
        else
            phi_c = ZW'(ac) <<< 7;
    end

    // ---------------- stage S_HALF: range fold for the rotation CORDIC ----------------
    logic signed [ZW-1:0] hz_c;
    logic                 hneg_c;

    always_comb
    begin
        hz_c   = phi_reg;
        hneg_c = 1'b0;
        if (phi_reg > HALF_PI_Q20)
        begin
            hz_c   = phi_reg - PI_Q20;
            hneg_c = 1'b1;
        end
        else if (phi_reg < -HALF_PI_Q20)
        begin
            hz_c   = phi_reg + PI_Q20;
            hneg_c = 1'b1;
        end
    end

    // ---------------- rotation CORDIC: cos/sin in Q.30 ----------------
    logic signed [RW-1:0] rx [STEPS+1];
    logic signed [RW-1:0] ry [STEPS+1];
    logic signed [ZW-1:0] rz [STEPS+1];
    logic signed [RW-1:0] rx0_reg, ry0_reg;
    logic signed [ZW-1:0] rz0_reg;

    assign rx[0] = rx0_reg;
    assign ry[0] = ry0_reg;
    assign rz[0] = rz0_reg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_rot
        hjal_rot_cell u_rot (
            .clk   (clk),
            .en    (en),
            .idx   (5'(i)),
            .x_in  (rx[i]),
            .y_in  (ry[i]),
            .z_in  (rz[i]),
            .x_reg (rx[i+1]),
            .y_reg (ry[i+1]),
            .z_reg (rz[i+1])
        );
    end

    // ---------------- stage S_QUAT: axis-angle quaternion ----------------
    function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
        if (v > 21'sd32767)
            return 16'sh7fff;
        else if (v < -21'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    logic signed [RW-1:0] co, si;
    logic signed [RW:0]   cor;
    logic signed [49:0]   shp [3];
    logic signed [49:0]   shr [3];
    logic signed [15:0]   q_c [4];
    logic signed [15:0]   q_reg [4];

    always_comb
    begin
        co     = side_reg[S_ROT].hneg ? -rx[STEPS] : rx[STEPS];
        si     = side_reg[S_ROT].hneg ? -ry[STEPS] : ry[STEPS];
        cor    = ((RW+1)'(co) + 35'sd32768) >>> 16;
        q_c[0] = sat16(cor[20:0]);
        shp[0] = si * hinge_x_reg;
        shp[1] = si * hinge_y_reg;
        shp[2] = si * hinge_z_reg;
        for (int k = 0; k < 3; k++)
        begin
            shr[k]   = (shp[k] + 50'sd536870912) >>> 30;
            q_c[k+1] = sat16(shr[k][20:0]);
        end
    end

    // ---------------- output stage: change test ----------------
    logic signed [33:0] dot_c;
    logic signed [33:0] dr_c;
    logic signed [20:0] diff_c, adiff_c;
    logic               keep_c;
    side_t              sq;

    always_comb
    begin
        sq      = side_reg[S_QUAT];
        dot_c   = q_reg[0] * sq.w + q_reg[1] * sq.x + q_reg[2] * sq.y + q_reg[3] * sq.z;
        dr_c    = (dot_c + 34'sd8192) >>> 14;
        diff_c  = 21'sd16384 - dr_c[20:0];
        adiff_c = diff_c[20] ? -diff_c : diff_c;
        keep_c  = !sq.near && (adiff_c <= 21'(CHANGE_TOL));
    end

    logic signed [15:0] res_w_reg, res_x_reg, res_y_reg, res_z_reg;
    logic               res_applied_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else if (en)
            res_vld_reg <= vld_reg[NST-1];
    end

    // side band entries that pick up a flag on their way in
    side_t side_fp_c, side_prep_c, side_half_c;

    always_comb
    begin
        side_fp_c           = side_reg[S_FP-1];
        side_fp_c.near      = near_c;
        side_prep_c         = side_reg[S_PREP-1];
        side_prep_c.fix     = s_zero;
        side_prep_c.fix_neg = c_neg;
        side_prep_c.z0      = pz_c;
        side_half_c         = side_reg[S_HALF-1];
        side_half_c.hneg    = hneg_c;
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < NST; k++)
            begin
                if (k == S_FP)
                    side_reg[k] <= side_fp_c;
                else if (k == S_PREP)
                    side_reg[k] <= side_prep_c;
                else if (k == S_HALF)
                    side_reg[k] <= side_half_c;
                else
                    side_reg[k] <= side_reg[k-1];
            end

            for (int k = 0; k < 3; k++)
            begin
                t_reg[k]  <= {c1[k], 1'b0};
                v_reg[k]  <= vr[k][24:0];
                v2_reg[k] <= v_reg[k];
                p_reg[k]  <= pr[k][31:0];
                fp_reg[k] <= fp_c[k];
            end
            d_reg   <= d_c;
            c4_reg  <= c_c;
            c5_reg  <= c4_reg;
            s_reg   <= s_c;
            nx0_reg <= px_c;
            ny0_reg <= py_c;

            a_reg   <= ar_c[17:0];
            phi_reg <= phi_c;
            rx0_reg <= GAIN_Q30;
            ry0_reg <= '0;
            rz0_reg <= hz_c;

            for (int k = 0; k < 4; k++)
                q_reg[k] <= q_c[k];

            res_w_reg       <= keep_c ? sq.w : q_reg[0];
            res_x_reg       <= keep_c ? sq.x : q_reg[1];
            res_y_reg       <= keep_c ? sq.y : q_reg[2];
            res_z_reg       <= keep_c ? sq.z : q_reg[3];
            res_applied_reg <= !keep_c;
        end
    end

    assign result.valid   = res_vld_reg;
    assign result.w       = res_w_reg;
    assign result.x       = res_x_reg;
    assign result.y       = res_y_reg;
    assign result.z       = res_z_reg;
    assign result.applied = res_applied_reg;

    // vectoring input magnitude, for the normalizer check
    logic signed [NW-1:0] nya, nmax;

    assign nya  = ny[NDN+NUP][NW-1] ? -ny[NDN+NUP] : ny[NDN+NUP];
    assign nmax = (nx[NDN+NUP] > nya) ? nx[NDN+NUP] : nya;

`ifndef ASSERT_OFF
    // normalizer must land every live, non-degenerate vector in its window
    a_norm_window: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[S_NORM] && !side_reg[S_NORM].fix |-> (nmax >= NORM_LO) && (nmax < NORM_HI))
        else $error("normalizer output out of window");

    // a short remainder always reports applied
    a_near_applied: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[NST-1] && side_reg[NST-1].near |=> res_applied_reg)
        else $error("short remainder result not marked applied");

    // a stall freezes the valid line
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> (vld_reg == $past(vld_reg)) && res_vld_reg)
        else $error("pipeline moved during stall");
`endif

endmodule

// ===== rtl/hjal_dn_cell.sv =====
module hjal_dn_cell import hjal_pkg::*; (
    input  logic                 clk,
    input  logic                 en,
    input  logic [5:0]           sh,
    input  logic signed [NW-1:0] x_in,
    input  logic signed [NW-1:0] y_in,
    output logic signed [NW-1:0] x_reg,
    output logic signed [NW-1:0] y_reg
);

    logic signed [NW-1:0] xt, yt, x_next, y_next;
    logic                 fits;

    // greedy search bit: take this shift only if one less is not yet enough
    always_comb
    begin
        xt     = x_in >>> (sh - 6'd1);
        yt     = y_in >>> (sh - 6'd1);
        fits   = (xt < NORM_HI) && (yt < NORM_HI) && (yt > -NORM_HI);
        x_next = fits ? x_in : (x_in >>> sh);
        y_next = fits ? y_in : (y_in >>> sh);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

endmodule

// ===== rtl/hjal_up_cell.sv =====
module hjal_up_cell import hjal_pkg::*; (
    input  logic                 clk,
    input  logic                 en,
    input  logic [5:0]           sh,
    input  logic signed [NW-1:0] x_in,
    input  logic signed [NW-1:0] y_in,
    output logic signed [NW-1:0] x_reg,
    output logic signed [NW-1:0] y_reg
);

    logic signed [NW-1:0] ya, m, x_next, y_next;
    logic                 big;

    always_comb
    begin
        ya     = y_in[NW-1] ? -y_in : y_in;
        m      = (x_in > ya) ? x_in : ya;
        big    = m >= (NORM_HI >>> sh);
        x_next = big ? x_in : (x_in <<< sh);
        y_next = big ? y_in : (y_in <<< sh);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

endmodule

// ===== rtl/hjal_vec_cell.sv =====
module hjal_vec_cell import hjal_pkg::*; (
    input  logic                 clk,
    input  logic                 en,
    input  logic [4:0]           idx,
    input  logic signed [VW-1:0] x_in,
    input  logic signed [VW-1:0] y_in,
    input  logic signed [ZW-1:0] z_in,
    output logic signed [VW-1:0] x_reg,
    output logic signed [VW-1:0] y_reg,
    output logic signed [ZW-1:0] z_reg
);

    logic signed [VW-1:0] xs, ys, x_next, y_next;
    logic signed [ZW-1:0] at, z_next;
    logic                 ypos;

    always_comb
    begin
        at   = $signed({{(ZW-20){1'b0}}, ATAN_Q20[idx]});
        xs   = x_in >>> idx;
        ys   = y_in >>> idx;
        ypos = !y_in[VW-1] && (y_in != '0);
        if (ypos)
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + at;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

endmodule

// ===== rtl/hjal_rot_cell.sv =====
module hjal_rot_cell import hjal_pkg::*; (
    input  logic                 clk,
    input  logic                 en,
    input  logic [4:0]           idx,
    input  logic signed [RW-1:0] x_in,
    input  logic signed [RW-1:0] y_in,
    input  logic signed [ZW-1:0] z_in,
    output logic signed [RW-1:0] x_reg,
    output logic signed [RW-1:0] y_reg,
    output logic signed [ZW-1:0] z_reg
);

    logic signed [RW-1:0] xs, ys, x_next, y_next;
    logic signed [ZW-1:0] at, z_next;

    always_comb
    begin
        at = $signed({{(ZW-20){1'b0}}, ATAN_Q20[idx]});
        xs = x_in >>> idx;
        ys = y_in >>> idx;
        if (!z_in[ZW-1])
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - at;
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

endmodule
